>>> src/dudq_pkg.sv
package dudq_pkg;

  // Ring length of the original scheme; one slot stays unused, so the
  // chain holds one entry less.
  localparam int QUEUE_LEN  = 16;
  localparam int CELL_COUNT = QUEUE_LEN - 1;

  // Ports at or above PORT_COUNT are rejected. The value store always has
  // eight slots, addressed by the three bits of a stored port.
  localparam int PORT_COUNT = 8;
  localparam int PORT_SLOTS = 8;
  localparam int PORT_W     = $clog2(PORT_SLOTS);
  localparam int IN_PORT_W  = 4;
  localparam int IN_VALUE_W = 16;
  localparam int VALUE_W    = 12;
  localparam int STATUS_W   = 3;

  localparam logic [IN_PORT_W-1:0] PORT_LIMIT = IN_PORT_W'(PORT_COUNT);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_POP   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_QUEUED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PENDING   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_PORT  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_POP_EMPTY = 3'd4;

  // Control broadcast from the sequencer to every cell of the chain.
  typedef struct packed {
    logic cmp;    // compare the stored entry against the key
    logic shift;  // take the upper neighbor's entry (pop)
    logic push;   // the first empty cell takes the new entry
  } cell_ctrl_t;

endpackage

>>> src/dudq_cell.sv
module dudq_cell
  import dudq_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  cell_ctrl_t        ctrl,
  input  logic [PORT_W-1:0] key,
  input  logic              up_valid,
  input  logic [PORT_W-1:0] up_entry,
  input  logic              down_valid,
  output logic              valid,
  output logic [PORT_W-1:0] entry,
  output logic              match
);

  logic take_push;

  // Entries are packed toward the head, so the first empty cell is the one
  // whose lower neighbor is occupied.
  assign take_push = ctrl.push && !valid && down_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.shift) begin
      valid <= up_valid;
    end else if (take_push) begin
      valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      entry <= up_entry;
    end else if (take_push) begin
      entry <= key;
    end
    if (ctrl.cmp) begin
      match <= valid && (entry == key);
    end
  end

endmodule

>>> src/dac_update_dedup_queue.sv
// Deduplicating queue of pending DAC updates.
// Input channel s_*: one transfer is one command. tuser carries cmd
// (0 = write a port value, 1 = pop the oldest pending update); tdata carries
// the port in bits 3..0 and the requested value in bits 19..4.
// Output channel m_*: exactly one result transfer per command. tuser carries
// the status in bits 2..0 and out_valid in bit 3; tdata carries out_port in
// bits 2..0 and the 12-bit out_value in bits 14..3.
// Pending ports sit in a chain of cells, oldest at cell 0. A pop shifts the
// chain down by one, a write lands in the first empty cell, and the pending
// check is a compare done by all cells at once and registered per cell.
// A command passes through capture, per-cell compare, and decide and
// update before its result is offered. The block accepts one command at
// a time: it takes no new command until the last one has finished its
// decide step.
// Reset empties the chain and the output register; stored port values are
// not cleared and are only read after a write has set them.
// If the receiver stalls, the finished result waits in the output register;
// a new command can be accepted meanwhile, but its decide step waits until
// the output register is free.
module dac_update_dedup_queue
  import dudq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // port [3:0], value [19:4], zero [23:20]
  input  logic [0:0]  s_tuser,   // cmd [0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // out_port [2:0], out_value [14:3], zero [15]
  output logic [3:0]  m_tuser    // status [2:0], out_valid [3]
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_DEC  = 3'b100
  } state_t;

  state_t state, state_next;

  // Captured command.
  logic                 req_cmd;
  logic [IN_PORT_W-1:0] req_port;
  logic [VALUE_W-1:0]   req_value;

  // Latest value per port.
  logic [VALUE_W-1:0] port_values [PORT_SLOTS];

  // Chain of cells.
  cell_ctrl_t            ctrl;
  logic [CELL_COUNT-1:0] cell_valid;
  logic [CELL_COUNT-1:0] cell_match;
  logic [PORT_W-1:0]     cell_entry [CELL_COUNT];

  // Output register.
  logic [STATUS_W-1:0] res_status, out_status;
  logic                res_valid, out_valid;
  logic [PORT_W-1:0]   res_port, out_port;
  logic [VALUE_W-1:0]  res_value, out_value;

  logic in_xfer, out_free, decide, hit, full, empty, bad_port, val_write;

  assign s_tready = (state == S_IDLE);
  assign in_xfer  = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign decide   = (state == S_DEC) && out_free;

  assign hit      = |cell_match;
  assign full     = cell_valid[CELL_COUNT-1];
  assign empty    = !cell_valid[0];
  assign bad_port = (req_port >= PORT_LIMIT);

  genvar gi;
  generate
    for (gi = 0; gi < CELL_COUNT; gi++) begin : g_cell
      logic              up_valid;
      logic [PORT_W-1:0] up_entry;
      logic              down_valid;

      if (gi == CELL_COUNT - 1) begin : g_top
        assign up_valid = 1'b0;
        assign up_entry = '0;
      end else begin : g_mid
        assign up_valid = cell_valid[gi+1];
        assign up_entry = cell_entry[gi+1];
      end

      if (gi == 0) begin : g_head
        assign down_valid = 1'b1;
      end else begin : g_rest
        assign down_valid = cell_valid[gi-1];
      end

      dudq_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .key        (req_port[PORT_W-1:0]),
        .up_valid   (up_valid),
        .up_entry   (up_entry),
        .down_valid (down_valid),
        .valid      (cell_valid[gi]),
        .entry      (cell_entry[gi]),
        .match      (cell_match[gi])
      );
    end
  endgenerate

  // Sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_CMP;
        end
      end
      S_CMP: begin
        state_next = S_DEC;
      end
      S_DEC: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_cmd   <= s_tuser[0];
      req_port  <= s_tdata[IN_PORT_W-1:0];
      req_value <= s_tdata[IN_PORT_W +: VALUE_W];
    end
  end

  // Compare strobe, and the result and chain updates for the decide step.
  always_comb begin
    ctrl       = '0;
    ctrl.cmp   = (state == S_CMP);
    res_status = ST_QUEUED;
    res_valid  = 1'b0;
    res_port   = '0;
    res_value  = '0;
    val_write  = 1'b0;
    if (req_cmd == CMD_POP) begin
      if (empty) begin
        res_status = ST_POP_EMPTY;
      end else begin
        res_status = ST_QUEUED;
        res_valid  = 1'b1;
        res_port   = cell_entry[0];
        res_value  = port_values[cell_entry[0]];
        ctrl.shift = decide;
      end
    end else if (bad_port) begin
      res_status = ST_BAD_PORT;
    end else begin
      val_write = decide;
      if (hit) begin
        res_status = ST_PENDING;
      end else if (full) begin
        res_status = ST_FULL;
      end else begin
        res_status = ST_QUEUED;
        ctrl.push  = decide;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (val_write) begin
      port_values[req_port[PORT_W-1:0]] <= req_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (decide) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (decide) begin
      out_status <= res_status;
      out_valid  <= res_valid;
      out_port   <= res_port;
      out_value  <= res_value;
    end
  end

  assign m_tuser = {out_valid, out_status};
  assign m_tdata = {1'b0, out_value, out_port};

endmodule

>>> sim/dac_update_checker.sv
`timescale 1ns / 100ps

module dac_update_checker
  import dudq_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [23:0] s_tdata,   // port [3:0], value [19:4], zero [23:20]
  input  logic [0:0]  s_tuser,   // cmd [0]
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,   // out_port [2:0], out_value [14:3], zero [15]
  input  logic [3:0]  m_tuser,   // status [2:0], out_valid [3]
  output int          error_count,
  output int          results_owed,
  output int          results_checked
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                delivered;
    logic [PORT_W-1:0]   port;
    logic [VALUE_W-1:0]  value;
  } dac_result_t;

  logic [VALUE_W-1:0] port_level [PORT_SLOTS];
  logic [PORT_W-1:0]  pend_ring  [QUEUE_LEN];
  int                 wr_pos;
  int                 rd_pos;
  dac_result_t        owed_results [$];

  function automatic int ring_next(int idx);
    return (idx == QUEUE_LEN - 1) ? 0 : idx + 1;
  endfunction

  // Applies one command to the shadow state and returns its result.
  function automatic dac_result_t predict_update(logic cmd, logic [IN_PORT_W-1:0] port,
                                                 logic [IN_VALUE_W-1:0] value);
    dac_result_t res;
    int          idx;
    int          nxt;
    bit          found;
    res   = '0;
    found = 1'b0;
    if (cmd == CMD_POP) begin
      if (wr_pos == rd_pos) begin
        res.status = ST_POP_EMPTY;
      end else begin
        res.status    = ST_QUEUED;
        res.delivered = 1'b1;
        res.port      = pend_ring[rd_pos];
        res.value     = port_level[res.port];
        rd_pos        = ring_next(rd_pos);
      end
    end else if (port >= PORT_LIMIT) begin
      res.status = ST_BAD_PORT;
    end else begin
      // The value is kept even when the port is already waiting or the ring is full.
      port_level[port[PORT_W-1:0]] = value[VALUE_W-1:0];
      idx = rd_pos;
      while (idx != wr_pos && !found) begin
        found = (pend_ring[idx] == port[PORT_W-1:0]);
        idx   = ring_next(idx);
      end
      if (found) begin
        res.status = ST_PENDING;
      end else begin
        nxt = ring_next(wr_pos);
        if (nxt == rd_pos) begin
          res.status = ST_FULL;
        end else begin
          pend_ring[wr_pos] = port[PORT_W-1:0];
          wr_pos            = nxt;
          res.status        = ST_QUEUED;
        end
      end
    end
    return res;
  endfunction

  function automatic int check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, got %0d", name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    dac_result_t exp_res;
    int          bad;
    if (rst) begin
      wr_pos = 0;
      rd_pos = 0;
      foreach (port_level[i]) port_level[i] = '0;
      foreach (pend_ring[i]) pend_ring[i] = '0;
      owed_results.delete();
      error_count     <= 0;
      results_checked <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        owed_results.push_back(predict_update(s_tuser[0], s_tdata[3:0], s_tdata[19:4]));
      end
      if (m_tvalid && m_tready) begin
        if (owed_results.size() == 0) begin
          $error("result transfer with no command waiting for one");
          error_count <= error_count + 1;
        end else begin
          exp_res = owed_results.pop_front();
          bad = 0;
          bad += check_field("status", int'(exp_res.status), int'(m_tuser[2:0]));
          bad += check_field("out_valid", int'(exp_res.delivered), int'(m_tuser[3]));
          bad += check_field("out_port", int'(exp_res.port), int'(m_tdata[2:0]));
          bad += check_field("out_value", int'(exp_res.value), int'(m_tdata[14:3]));
          bad += check_field("tdata padding", 0, int'(m_tdata[15]));
          error_count     <= error_count + bad;
          results_checked <= results_checked + 1;
        end
      end
    end
    results_owed <= owed_results.size();
  end

endmodule

>>> sim/dac_update_dedup_queue_tb.sv
`timescale 1ns / 100ps

module dac_update_dedup_queue_tb
  import dudq_pkg::*;
;

  // The run is bounded by this many clock cycles. A correct run needs a
  // small fraction of it even with both sides idling at their heaviest.
  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_ITEMS = 1100;
  // This many quiet cycles at the end catch any stray result transfer.
  localparam int TAIL_CYCLES  = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // port [3:0], value [19:4], zero [23:20]
  logic [0:0]  s_tuser = '0;   // cmd [0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // out_port [2:0], out_value [14:3], zero [15]
  logic [3:0]  m_tuser;        // status [2:0], out_valid [3]

  int error_count;
  int results_owed;
  int results_checked;

  int cycle_count   = 0;
  int send_idle_pct = 33;
  int recv_idle_pct = 45;
  int n_writes      = 0;
  int n_pops        = 0;
  int n_bad_ports   = 0;

  dac_update_dedup_queue dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  dac_update_checker scoreboard (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .m_tuser         (m_tuser),
    .error_count     (error_count),
    .results_owed    (results_owed),
    .results_checked (results_checked)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // The receiver drops tready at random in the current idle share. The draw
  // is made anew every cycle, so stalls land on each of the block's capture,
  // compare and decide steps, including while a finished result is waiting.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: a hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offers one command and returns at the edge where its transfer happens.
  // Random idle cycles go in front of the offer. tvalid is left high on
  // return so that back-to-back commands never lower and raise it within
  // one time step; the next call or the drain below lowers it.
  task automatic send_cmd(input logic cmd, input logic [IN_PORT_W-1:0] port,
                          input logic [IN_VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {4'b0000, value, port};
    if (cmd == CMD_POP) begin
      n_pops++;
    end else begin
      n_writes++;
      if (port >= PORT_LIMIT) n_bad_ports++;
    end
    do @(posedge clk); while (!s_tready);
  endtask

  // Holds the sender off until every predicted result has been received.
  // The extra edge first lets the checker count the last accepted command.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
  endtask

  // Random traffic. The pop share changes every 40 commands so that the
  // queue swings between holding all eight ports and running empty, and
  // the ring pointers wrap many times. About one write in ten names a port
  // out of range. A pop still carries random port and value bits, which the
  // block must ignore.
  task automatic send_random(input int count);
    int pop_pct;
    logic [IN_PORT_W-1:0] port;
    pop_pct = 50;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) begin
        case ($urandom_range(2))
          0: pop_pct = 15;
          1: pop_pct = 50;
          default: pop_pct = 80;
        endcase
      end
      if ($urandom_range(99) < pop_pct) begin
        send_cmd(CMD_POP, IN_PORT_W'($urandom), IN_VALUE_W'($urandom));
      end else begin
        if ($urandom_range(99) < 10) begin
          port = IN_PORT_W'($urandom_range(15, PORT_COUNT));
        end else begin
          port = IN_PORT_W'($urandom_range(PORT_COUNT - 1, 0));
        end
        send_cmd(CMD_WRITE, port, IN_VALUE_W'($urandom));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part. A pop right after reset must report an empty queue.
    send_cmd(CMD_POP, 4'd0, 16'h0000);
    // All value bits set: only the low twelve survive. The second write to
    // the same port finds it waiting and only refreshes the value.
    send_cmd(CMD_WRITE, 4'd0, 16'hFFFF);
    send_cmd(CMD_WRITE, 4'd0, 16'h1234);
    send_cmd(CMD_WRITE, 4'd7, 16'h0000);
    // First and last port out of range change nothing.
    send_cmd(CMD_WRITE, 4'd8, 16'hABCD);
    send_cmd(CMD_WRITE, 4'd15, 16'hFFFF);
    send_cmd(CMD_POP, 4'd15, 16'hFFFF);
    send_cmd(CMD_POP, 4'd0, 16'h0000);
    send_cmd(CMD_POP, 4'd0, 16'h0000);
    // Every port waiting at once. With only eight ports and duplicates
    // merged, the ring never reaches its fifteen-entry limit, so the
    // queue-full drop cannot occur in this configuration.
    for (int p = 0; p < PORT_COUNT; p++) begin
      send_cmd(CMD_WRITE, IN_PORT_W'(p), IN_VALUE_W'(16'h0F00 + p * 16'h1111));
    end
    send_cmd(CMD_WRITE, 4'd5, 16'h5FFF);
    for (int p = 0; p < PORT_COUNT; p++) begin
      send_cmd(CMD_POP, 4'd0, 16'h0000);
    end
    drain_results();

    // First phase: the sender idles less than the receiver.
    send_idle_pct = 33;
    recv_idle_pct = 45;
    send_random(RANDOM_ITEMS / 3);
    // The sender stops until the block has nothing left to deliver.
    drain_results();

    // Second phase: the receiver is now the faster side.
    send_idle_pct = 45;
    recv_idle_pct = 33;
    send_random(RANDOM_ITEMS / 3);
    drain_results();

    // Third phase: neither side idles, so commands arrive back to back.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_random(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
    drain_results();

    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Run covered %0d commands: %0d writes (%0d out of range) and %0d pops.",
             n_writes + n_pops, n_writes, n_bad_ports, n_pops);
    $display("Compared %0d results under three sender/receiver idle mixes.",
             results_checked);
    if (error_count == 0 && results_owed == 0) begin
      $display("Simulation PASSED");
    end else begin
      if (results_owed != 0) $error("%0d results never arrived", results_owed);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
